/* rtl/tdm_pkg.sv */
// ============================================================================
// tdm_pkg - throttle duty mapper shared definitions
// Item types, fixed widths, queue depths and the step-rate lookup used by the
// front and back parts of the mapper.
// ============================================================================
package tdm_pkg;

    // Field widths
    localparam int SAMPLE_BITS = 10;
    localparam int LEVEL_BITS  = 7;
    localparam int WIDE_BITS   = 16;
    localparam int RATE_BITS   = 8;
    localparam int DUTY_BITS   = 9;
    localparam int QUO_BITS    = 9;
    localparam int SUM_BITS    = 10;

    // Saturation limit of the PWM duty
    localparam logic [DUTY_BITS-1:0] DUTY_MAX = 9'd511;

    // Divider pipeline shape: QUO_BITS = DIV_STAGES * STEPS_PER_STAGE
    localparam int DIV_STAGES      = 3;
    localparam int STEPS_PER_STAGE = 3;

    // Queue depths (powers of two)
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 2;

    // One input item
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] light_sample;
        logic [SAMPLE_BITS-1:0] speed_sample;
    } in_item_t;

    // One result item
    typedef struct packed {
        logic [DUTY_BITS-1:0] duty;
        logic                 clamped;
    } out_item_t;

    // Classified item handed from front to back
    typedef struct packed {
        logic [LEVEL_BITS-1:0] light;
        logic [WIDE_BITS-1:0]  speed;
        logic [RATE_BITS-1:0]  rate;
    } work_t;

    // Divider stage contents
    typedef struct packed {
        logic [LEVEL_BITS-1:0] light;
        logic [WIDE_BITS-1:0]  speed;
        logic [RATE_BITS-1:0]  rate;
        logic [RATE_BITS-1:0]  rem;
        logic [QUO_BITS-1:0]   quo;
    } div_t;

    // Step rate: 65535 / (511 - light), truncated, for light 0..127
    function automatic logic [RATE_BITS-1:0] rate_of(input logic [LEVEL_BITS-1:0] light);
        logic [RATE_BITS-1:0] r;
        unique case (light) inside
            [7'd0   : 7'd2  ]: r = 8'd128;
            [7'd3   : 7'd6  ]: r = 8'd129;
            [7'd7   : 7'd10 ]: r = 8'd130;
            [7'd11  : 7'd14 ]: r = 8'd131;
            [7'd15  : 7'd18 ]: r = 8'd132;
            [7'd19  : 7'd21 ]: r = 8'd133;
            [7'd22  : 7'd25 ]: r = 8'd134;
            [7'd26  : 7'd29 ]: r = 8'd135;
            [7'd30  : 7'd32 ]: r = 8'd136;
            [7'd33  : 7'd36 ]: r = 8'd137;
            [7'd37  : 7'd39 ]: r = 8'd138;
            [7'd40  : 7'd42 ]: r = 8'd139;
            [7'd43  : 7'd46 ]: r = 8'd140;
            [7'd47  : 7'd49 ]: r = 8'd141;
            [7'd50  : 7'd52 ]: r = 8'd142;
            [7'd53  : 7'd55 ]: r = 8'd143;
            [7'd56  : 7'd59 ]: r = 8'd144;
            [7'd60  : 7'd62 ]: r = 8'd145;
            [7'd63  : 7'd65 ]: r = 8'd146;
            [7'd66  : 7'd68 ]: r = 8'd147;
            [7'd69  : 7'd71 ]: r = 8'd148;
            [7'd72  : 7'd74 ]: r = 8'd149;
            [7'd75  : 7'd76 ]: r = 8'd150;
            [7'd77  : 7'd79 ]: r = 8'd151;
            [7'd80  : 7'd82 ]: r = 8'd152;
            [7'd83  : 7'd85 ]: r = 8'd153;
            [7'd86  : 7'd88 ]: r = 8'd154;
            [7'd89  : 7'd90 ]: r = 8'd155;
            [7'd91  : 7'd93 ]: r = 8'd156;
            [7'd94  : 7'd96 ]: r = 8'd157;
            [7'd97  : 7'd98 ]: r = 8'd158;
            [7'd99  : 7'd101]: r = 8'd159;
            [7'd102 : 7'd103]: r = 8'd160;
            [7'd104 : 7'd106]: r = 8'd161;
            [7'd107 : 7'd108]: r = 8'd162;
            [7'd109 : 7'd111]: r = 8'd163;
            [7'd112 : 7'd113]: r = 8'd164;
            [7'd114 : 7'd116]: r = 8'd165;
            [7'd117 : 7'd118]: r = 8'd166;
            [7'd119 : 7'd120]: r = 8'd167;
            [7'd121 : 7'd123]: r = 8'd168;
            [7'd124 : 7'd125]: r = 8'd169;
            default:           r = 8'd170;
        endcase
        return r;
    endfunction

endpackage

/* rtl/tdm_fifo.sv */
// ============================================================================
// tdm_fifo - small register queue
// Power-of-two depth queue with push/full and pop/empty sides; the head entry
// is presented while empty is low.
// ============================================================================
module tdm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW:0] FULL_COUNT = (AW+1)'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic [AW:0]      count_next;
    logic             do_push;
    logic             do_pop;

    // Qualify the transfers
    assign full    = (count_reg == FULL_COUNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // Track fill level
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (AW+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (AW+1)'(1);
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            count_reg <= count_next;
        end
    end

    // Store written entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* rtl/tdm_front.sv */
// ============================================================================
// tdm_front - sample intake and classification
// Reduces the light sample to a level, widens the speed sample and looks up
// the step rate, holding the classified item until the middle queue takes it.
// ============================================================================
module tdm_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  tdm_pkg::in_item_t samples,
    output logic              mid_push,
    input  logic              mid_full,
    output tdm_pkg::work_t    mid_item
);

    import tdm_pkg::*;

    work_t                 item_reg;
    work_t                 item_next;
    logic                  vld_reg;
    logic                  vld_next;
    logic                  accept;
    logic [LEVEL_BITS-1:0] light;

    // Hold off the source only while the stage is occupied and blocked
    assign full     = vld_reg && mid_full;
    assign accept   = push && !full;
    assign mid_push = vld_reg && !mid_full;
    assign mid_item = item_reg;

    // Classify the incoming samples
    always_comb
    begin
        light           = samples.light_sample[SAMPLE_BITS-1 -: LEVEL_BITS];
        item_next.light = light;
        item_next.speed = WIDE_BITS'({samples.speed_sample,
                                      {(WIDE_BITS-SAMPLE_BITS){1'b0}}});
        item_next.rate  = rate_of(light);
    end

    // Track occupancy
    always_comb
    begin
        vld_next = vld_reg;
        if (accept)
        begin
            vld_next = 1'b1;
        end
        else if (mid_push)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Capture on each input transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

endmodule

/* rtl/tdm_back.sv */
// ============================================================================
// tdm_back - pipelined divide and saturate
// Divides the widened speed by the step rate in a three-stage restoring
// divider, adds the light level and saturates the duty.
// ============================================================================
module tdm_back (
    input  logic               clk,
    input  logic               rst_n,
    input  tdm_pkg::work_t     mid_item,
    input  logic               mid_empty,
    output logic               mid_pop,
    output logic               out_push,
    input  logic               out_full,
    output tdm_pkg::out_item_t out_item
);

    import tdm_pkg::*;

    localparam int LAST = DIV_STAGES - 1;

    div_t                  stage_reg  [DIV_STAGES];
    div_t                  stage_next [DIV_STAGES];
    logic [DIV_STAGES-1:0] vld_reg;
    logic [DIV_STAGES-1:0] vld_next;
    div_t                  first;
    logic                  en;
    logic [SUM_BITS-1:0]   sum;
    logic                  over;

    // Run a group of restoring division steps from quotient bit top down
    function automatic div_t div_steps(input div_t d, input logic [3:0] top);
        div_t       r;
        logic [8:0] trial;
        logic [3:0] idx;
        r = d;
        for (int k = 0; k < STEPS_PER_STAGE; k++)
        begin
            idx   = top - 4'(k);
            trial = {r.rem, r.speed[idx]};
            if (trial >= {1'b0, r.rate})
            begin
                trial      = trial - {1'b0, r.rate};
                r.quo[idx] = 1'b1;
            end
            r.rem = trial[RATE_BITS-1:0];
        end
        return r;
    endfunction

    // Stall the whole pipe while the result queue is full
    assign en      = !out_full;
    assign mid_pop = en && !mid_empty;

    // Seed the remainder with the bits above the quotient range
    always_comb
    begin
        first.light = mid_item.light;
        first.speed = mid_item.speed;
        first.rate  = mid_item.rate;
        first.rem   = {1'b0, mid_item.speed[WIDE_BITS-1 -: (WIDE_BITS-QUO_BITS)]};
        first.quo   = '0;
    end

    // Divide, three quotient bits per stage
    always_comb
    begin
        stage_next[0] = div_steps(first, 4'(QUO_BITS - 1));
        vld_next[0]   = mid_pop;
        for (int s = 1; s < DIV_STAGES; s++)
        begin
            stage_next[s] = div_steps(stage_reg[s-1],
                                      4'(QUO_BITS - 1 - s * STEPS_PER_STAGE));
            vld_next[s]   = vld_reg[s-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    // Add the level and saturate
    always_comb
    begin
        sum              = SUM_BITS'(stage_reg[LAST].light) + SUM_BITS'(stage_reg[LAST].quo);
        over             = (sum > SUM_BITS'(DUTY_MAX));
        out_item.clamped = over;
        out_item.duty    = over ? DUTY_MAX : sum[DUTY_BITS-1:0];
    end

    assign out_push = en && vld_reg[LAST];

endmodule

/* rtl/throttle_duty_mapper.sv */
// ============================================================================
// throttle_duty_mapper - converter samples to motor PWM duty
// Maps an idle-light and a speed sample to a saturated 9-bit duty value.
//
//   channel   ports                    transfer when
//   input     push, full, samples      push && !full
//   result    pop, empty, result       pop && !empty
//
// One item per cycle sustained while the sink keeps popping results; an item's
// result passes from its input transfer through the front register, which loads
// at the transfer, the middle queue, three divider stages (three quotient bits
// each) and the result queue.
// Reset clears all queue pointers and valid flags; no clearing pass.
// A full result queue stalls the divider; the middle queue lets the front keep
// taking items until it too fills.
// ============================================================================
module throttle_duty_mapper #(
    parameter int MID_DEPTH = tdm_pkg::MID_DEPTH,
    parameter int OUT_DEPTH = tdm_pkg::OUT_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  tdm_pkg::in_item_t  samples,
    output logic               empty,
    input  logic               pop,
    output tdm_pkg::out_item_t result
);

    import tdm_pkg::*;

    logic      mid_push;
    logic      mid_full;
    logic      mid_pop;
    logic      mid_empty;
    work_t     mid_wdata;
    work_t     mid_rdata;
    logic      out_push;
    logic      out_full;
    out_item_t out_wdata;

    // Intake and classify
    tdm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .samples  (samples),
        .mid_push (mid_push),
        .mid_full (mid_full),
        .mid_item (mid_wdata)
    );

    // Decouple front from back
    tdm_fifo #(
        .WIDTH ($bits(work_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .full  (mid_full),
        .wdata (mid_wdata),
        .pop   (mid_pop),
        .empty (mid_empty),
        .rdata (mid_rdata)
    );

    // Divide and saturate
    tdm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_item  (mid_rdata),
        .mid_empty (mid_empty),
        .mid_pop   (mid_pop),
        .out_push  (out_push),
        .out_full  (out_full),
        .out_item  (out_wdata)
    );

    // Hold results for the sink
    tdm_fifo #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .full  (out_full),
        .wdata (out_wdata),
        .pop   (pop),
        .empty (empty),
        .rdata (result)
    );

endmodule
